// ----- sv/lpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

    // Byte and length widths of the framing format, and the APB data and address widths.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Reset value of the maximum payload length register.
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = LEN_W'(1024);

    // Register indexes, taken from the word address.
    localparam logic REG_MAX_LENGTH = 1'b0;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DESYNC  = 1'b1;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_LOW     = 2'd0,
        PH_HIGH    = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // One result from the parser, with its presence flag.
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              is_last;
        logic [LEN_W-1:0]  bad_length;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/lpd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Received byte stream.
interface lpd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lpd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed result stream.
interface lpd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [lpd_pkg::BYTE_W-1:0] payload_byte;
    logic                       is_last;
    logic [lpd_pkg::LEN_W-1:0]  bad_length;

    modport source (output valid, output kind, output payload_byte, output is_last,
                    output bad_length, input ready);
    modport sink   (input valid, input kind, input payload_byte, input is_last,
                    input bad_length, output ready);
endinterface

`default_nettype wire

// ----- sv/length_prefix_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// i_rx      in         rx_byte
// o_pkt     out        kind, payload_byte, is_last, bad_length
// APB       in/out     max_length at byte address 0
//
// One byte is accepted every cycle while o_pkt is not stalled; each beat passes
// through the input register and then the result register before its result shows.
// Length bytes that start a packet give no result beat.
// Synchronous active-low reset clears the parser to wait for a low length byte.
// A stall on o_pkt holds the result; a byte is still taken into an empty input
// register, and i_rx.ready drops once the input register holds a byte.
module length_prefix_deframer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lpd_in_if.sink                          i_rx,
    lpd_out_if.source                       o_pkt,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [lpd_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [lpd_pkg::APB_DW-1:0] i_pwdata,
    output logic      [lpd_pkg::APB_DW-1:0] o_prdata,
    output logic                            o_pready
);
    import lpd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_result;
    logic [LEN_W-1:0]  w_max_length;
    logic              w_step;

    lpd_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (i_psel),
        .i_penable    (i_penable),
        .i_pwrite     (i_pwrite),
        .i_paddr      (i_paddr),
        .i_pwdata     (i_pwdata),
        .o_prdata     (o_prdata),
        .o_pready     (o_pready),
        .o_max_length (w_max_length)
    );

    lpd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_byte       (r_in_byte),
        .i_max_length (w_max_length),
        .o_result     (w_result)
    );

    // The held byte moves on when the result register is free or being drained.
    assign w_step     = r_in_valid && (!r_out_valid || o_pkt.ready);
    assign i_rx.ready = !r_in_valid || w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_result.valid;
        end else if (o_pkt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_pkt.valid        = r_out_valid;
    assign o_pkt.kind         = r_out.kind;
    assign o_pkt.payload_byte = r_out.payload_byte;
    assign o_pkt.is_last      = r_out.is_last;
    assign o_pkt.bad_length   = r_out.bad_length;

endmodule

`default_nettype wire

// ----- sv/lpd_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpd_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [lpd_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [lpd_pkg::APB_DW-1:0] i_pwdata,
    output logic      [lpd_pkg::APB_DW-1:0] o_prdata,
    output logic                            o_pready,
    output logic      [lpd_pkg::LEN_W-1:0]  o_max_length
);
    import lpd_pkg::*;

    logic             w_wr;
    logic             w_index;
    logic [LEN_W-1:0] r_max_length;

    assign w_index = i_paddr[APB_AW-1];
    assign w_wr    = i_psel && i_penable && i_pwrite;

    // Register write in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (w_wr && (w_index == REG_MAX_LENGTH)) begin
            r_max_length <= i_pwdata[LEN_W-1:0];
        end
    end

    // Read decode; unmapped addresses read as zero.
    always_comb begin
        unique case (w_index)
            REG_MAX_LENGTH: o_prdata = {{(APB_DW-LEN_W){1'b0}}, r_max_length};
            default:        o_prdata = '0;
        endcase
    end

    assign o_pready     = 1'b1;
    assign o_max_length = r_max_length;

endmodule

`default_nettype wire

// ----- sv/lpd_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lpd_parse (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [lpd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [lpd_pkg::LEN_W-1:0]  i_max_length,
    output lpd_pkg::t_result                o_result
);
    import lpd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_held, n_held;
    logic [LEN_W-1:0]  r_remaining, n_remaining;
    logic [LEN_W-1:0]  w_len;
    logic              w_bad_len;
    logic [LEN_W-1:0]  w_dec;
    logic              w_last;

    // Length assembled from the held low byte and this high byte.
    assign w_len     = {i_byte, r_held};
    assign w_bad_len = (w_len == '0) || (w_len > i_max_length);
    assign w_dec     = r_remaining - LEN_W'(1);
    assign w_last    = (w_dec == '0);

    // Next state.
    always_comb begin
        n_phase     = r_phase;
        n_held      = r_held;
        n_remaining = r_remaining;
        unique case (r_phase)
            PH_HIGH: begin
                if (w_bad_len) begin
                    // Slide by one byte: the high byte becomes the new low byte.
                    n_held = i_byte;
                end else begin
                    n_remaining = w_len;
                    n_phase     = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_remaining = w_dec;
                if (w_last) begin
                    n_phase = PH_LOW;
                end
            end
            default: begin
                n_held  = i_byte;
                n_phase = PH_HIGH;
            end
        endcase
    end

    // Result for the byte being processed.
    always_comb begin
        o_result = '0;
        unique case (r_phase)
            PH_HIGH: begin
                if (w_bad_len) begin
                    o_result.valid      = 1'b1;
                    o_result.kind       = KIND_DESYNC;
                    o_result.bad_length = w_len;
                end
            end
            PH_PAYLOAD: begin
                o_result.valid        = 1'b1;
                o_result.kind         = KIND_PAYLOAD;
                o_result.payload_byte = i_byte;
                o_result.is_last      = w_last;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // State registers advance once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LOW;
            r_held      <= '0;
            r_remaining <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_remaining <= n_remaining;
        end
    end

endmodule

`default_nettype wire
